@@ rtl/core/hld_pkg.sv @@
package hld_pkg;

    localparam int ADDR_W  = 32;
    localparam int COUNT_W = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'd1;

    localparam logic               ENABLE_RESET    = 1'b1;
    localparam logic [COUNT_W-1:0] THRESHOLD_RESET = 16'd50;
    localparam logic [COUNT_W-1:0] COUNT_MAX       = 16'hFFFF;
    localparam logic [COUNT_W-1:0] COUNT_FIRST     = 16'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE,
        ST_APPEND,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic capture;
        logic start_scan;
        logic advance;
        logic take_match;
        logic update;
        logic append;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic skip;
        logic empty;
        logic full;
        logic match;
        logic last;
        logic out_free;
    } t_status;

endpackage

@@ rtl/core/hld_ram.sv @@
module hld_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH > 1 ? DEPTH : 2)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/hld_ctrl.sv @@
module hld_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  hld_pkg::t_status i_status,
    output hld_pkg::t_cmd   o_cmd
);

    hld_pkg::t_state r_state;
    hld_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hld_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            hld_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_status.skip) begin
                        n_state = hld_pkg::ST_DONE;
                    end else if (i_status.empty) begin
                        n_state = hld_pkg::ST_APPEND;
                    end else begin
                        n_state = hld_pkg::ST_SCAN;
                    end
                end
            end
            hld_pkg::ST_SCAN: begin
                if (i_status.match) begin
                    n_state = hld_pkg::ST_UPDATE;
                end else if (i_status.last) begin
                    n_state = i_status.full ? hld_pkg::ST_DONE : hld_pkg::ST_APPEND;
                end
            end
            hld_pkg::ST_UPDATE: n_state = hld_pkg::ST_DONE;
            hld_pkg::ST_APPEND: n_state = hld_pkg::ST_DONE;
            hld_pkg::ST_DONE: begin
                if (i_status.out_free) begin
                    n_state = hld_pkg::ST_IDLE;
                end
            end
            default: n_state = hld_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            hld_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture    = 1'b1;
                    o_cmd.start_scan = !i_status.skip && !i_status.empty;
                end
            end
            hld_pkg::ST_SCAN: begin
                if (i_status.match) begin
                    o_cmd.take_match = 1'b1;
                end else if (!i_status.last) begin
                    o_cmd.advance = 1'b1;
                end
            end
            hld_pkg::ST_UPDATE: o_cmd.update = 1'b1;
            hld_pkg::ST_APPEND: o_cmd.append = 1'b1;
            hld_pkg::ST_DONE:   o_cmd.load_out = i_status.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

@@ rtl/core/hld_datapath.sv @@
module hld_datapath #(
    parameter int TABLE_DEPTH = 128
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [hld_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [hld_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    input  logic [hld_pkg::ADDR_W-1:0]        i_loop_address,
    input  logic                              i_recording,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_hot,
    input  hld_pkg::t_cmd                     i_cmd,
    output hld_pkg::t_status                  o_status
);

    localparam int IDX_W  = $clog2(TABLE_DEPTH > 1 ? TABLE_DEPTH : 2);
    localparam int USED_W = $clog2(TABLE_DEPTH + 1);
    localparam int ENTRY_W = hld_pkg::ADDR_W + hld_pkg::COUNT_W;

    logic                          r_enable;
    logic [hld_pkg::COUNT_W-1:0]   r_threshold;
    logic [hld_pkg::ADDR_W-1:0]    r_addr;
    logic [IDX_W-1:0]              r_idx;
    logic [USED_W-1:0]             r_used;
    logic [hld_pkg::COUNT_W-1:0]   r_cnt;
    logic                          r_hot;
    logic                          r_out_valid;
    logic                          r_out_hot;

    logic [IDX_W-1:0]              rd_addr;
    logic [ENTRY_W-1:0]            rd_data;
    logic                          wr_en;
    logic [IDX_W-1:0]              wr_addr;
    logic [ENTRY_W-1:0]            wr_data;
    logic [hld_pkg::COUNT_W-1:0]   cnt_inc;
    logic                          cnt_hot;
    logic [hld_pkg::COUNT_W-1:0]   cnt_new;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable    <= hld_pkg::ENABLE_RESET;
            r_threshold <= hld_pkg::THRESHOLD_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                hld_pkg::CFG_ENABLE:    r_enable <= i_cfg_wdata[0];
                hld_pkg::CFG_THRESHOLD: r_threshold <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Saturating increment, then clear and flag hot at the threshold.
    assign cnt_inc = (r_cnt == hld_pkg::COUNT_MAX) ? r_cnt : r_cnt + 1'b1;
    assign cnt_hot = (cnt_inc >= r_threshold);
    assign cnt_new = cnt_hot ? '0 : cnt_inc;

    assign rd_addr = i_cmd.start_scan ? '0 : IDX_W'(r_idx + 1'b1);
    assign wr_en   = i_cmd.update || i_cmd.append;
    assign wr_addr = i_cmd.append ? r_used[IDX_W-1:0] : r_idx;
    assign wr_data = i_cmd.append ? {r_addr, hld_pkg::COUNT_FIRST} : {r_addr, cnt_new};

    hld_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_addr <= i_loop_address;
        end
        if (i_cmd.start_scan) begin
            r_idx <= '0;
        end else if (i_cmd.advance) begin
            r_idx <= IDX_W'(r_idx + 1'b1);
        end
        if (i_cmd.take_match) begin
            r_cnt <= rd_data[hld_pkg::COUNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used      <= '0;
            r_hot       <= 1'b0;
            r_out_valid <= 1'b0;
            r_out_hot   <= 1'b0;
        end else begin
            if (i_cmd.append) begin
                r_used <= USED_W'(r_used + 1'b1);
            end
            if (i_cmd.capture) begin
                r_hot <= 1'b0;
            end else if (i_cmd.update) begin
                r_hot <= cnt_hot;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
                r_out_hot   <= r_hot;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.skip     = !r_enable || i_recording;
    assign o_status.empty    = (r_used == '0);
    assign o_status.full     = (r_used == USED_W'(TABLE_DEPTH));
    assign o_status.match    = (rd_data[ENTRY_W-1:hld_pkg::COUNT_W] == r_addr);
    assign o_status.last     = (USED_W'(r_idx) + 1'b1 == r_used);
    assign o_status.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_hot       = r_out_hot;

endmodule

@@ rtl/core/hot_loop_detect_table.sv @@
// Hot loop detector: counts executions of loop back-edge addresses in a table.
// Input channel (i_in_valid / o_in_ready) takes one beat per executed back-edge:
// the address and the recording flag. Output channel (o_out_valid / i_out_ready)
// returns one beat per input beat carrying the hot flag, in input order.
// Configuration writes (i_cfg_we, i_cfg_index, i_cfg_wdata) take effect at once;
// index 0 is enable, index 1 is the hot threshold.
// A beat that is bypassed (disabled or recording) goes straight to the done state.
// A lookup scans the filled entries one per cycle through the table RAM: a hit
// updates the count of the matched entry, a miss appends the address unless the
// table is full, and a beat that meets an empty table is appended without a scan.
// The scan sets the pace of the input: the next beat is accepted
// in the cycle after the result is loaded into the output register.
// The output register lets a new beat be accepted while a result waits; if the
// receiver stalls longer, the following result is held and input stops.
// Reset empties the table (fill count to zero), sets enable to 1 and the
// threshold to 50, and drops any pending result. No clearing pass is needed.
module hot_loop_detect_table #(
    parameter int TABLE_DEPTH = 128
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [hld_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [hld_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [hld_pkg::ADDR_W-1:0]     i_loop_address,
    input  logic                           i_recording,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic                           o_hot
);

    hld_pkg::t_cmd    cmd;
    hld_pkg::t_status status;

    hld_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    hld_datapath #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_loop_address (i_loop_address),
        .i_recording    (i_recording),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_hot          (o_hot),
        .i_cmd          (cmd),
        .o_status       (status)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input accepted while a beat is in progress");

    a_load_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |-> (!o_out_valid || i_out_ready))
        else $error("result loaded over an untaken result");

    a_append_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.append |-> !status.full)
        else $error("append into a full table");

    a_single_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.append && cmd.update))
        else $error("append and update in the same cycle");

endmodule
